@@ hw/rtl/prefix_varint_decoder_defines.svh @@
// Assertion macros for the prefix varint decoder.
// Included by the files that carry concurrent checks; needs no package.
`ifndef PREFIX_VARINT_DECODER_DEFINES_SVH
`define PREFIX_VARINT_DECODER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PVD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define PVD_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/pvd_pkg.sv @@
// Package for the prefix varint decoder: field widths, lead-byte masks and codes.
// No dependencies.
package pvd_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned ValueW = 64;
   localparam int unsigned LenW   = 4;
   localparam int unsigned PendW  = 4;
   localparam int unsigned RspW   = 72;   // value + length, padded to whole bytes

   localparam logic [LenW-1:0] LenMax = 4'd15;

   // lead-byte class masks and patterns
   localparam logic [ByteW-1:0] MaskTop1 = 8'h80;
   localparam logic [ByteW-1:0] MaskTop2 = 8'hC0;
   localparam logic [ByteW-1:0] MaskTop4 = 8'hF0;
   localparam logic [ByteW-1:0] MaskTop6 = 8'hFC;
   localparam logic [ByteW-1:0] PatOne   = 8'h00;
   localparam logic [ByteW-1:0] PatTwo   = 8'h80;
   localparam logic [ByteW-1:0] PatThree = 8'hC0;
   localparam logic [ByteW-1:0] PatFour  = 8'hE0;
   localparam logic [ByteW-1:0] PatExt   = 8'hF0;

   // extended forms, selected by the top six bits
   localparam logic [ByteW-1:0] CodeWord32 = 8'hF0;
   localparam logic [ByteW-1:0] CodeWord64 = 8'hF4;
   localparam logic [ByteW-1:0] CodeNegate = 8'hF8;
   localparam logic [ByteW-1:0] CodeShortM = 8'hFC;

   // payload masks
   localparam logic [ByteW-1:0] Mask7 = 8'h7F;
   localparam logic [ByteW-1:0] Mask6 = 8'h3F;
   localparam logic [ByteW-1:0] Mask5 = 8'h1F;
   localparam logic [ByteW-1:0] Mask4 = 8'h0F;
   localparam logic [ByteW-1:0] Mask2 = 8'h03;

   // follow-on byte counts per form
   localparam logic [PendW-1:0] PendTwo   = 4'd1;
   localparam logic [PendW-1:0] PendThree = 4'd2;
   localparam logic [PendW-1:0] PendFour  = 4'd3;
   localparam logic [PendW-1:0] PendW32   = 4'd4;
   localparam logic [PendW-1:0] PendW64   = 4'd8;

   // zero-extend a masked byte to the value width
   function automatic logic [ValueW-1:0] widen(input logic [ByteW-1:0] b);
      widen = {{(ValueW-ByteW){1'b0}}, b};
   endfunction

endpackage

@@ hw/rtl/prefix_varint_decoder.sv @@
// Top level of the prefix varint decoder: byte stream in, decoded integers out.
// Depends on pvd_pkg and prefix_varint_decoder_defines.svh.
//
// The decoder takes one byte of a prefix-coded integer stream per transfer on the
// req_ channel and, when an integer completes, presents its 64-bit two's complement
// value and the number of bytes it used (prefixes included, saturating at 15) on the
// rsp_ channel. The decode of the lead byte, the shift of
// a follow-on byte into the accumulator and the optional complement all sit between
// the state registers and the result register. A result register decouples the two
// sides, so a new byte is taken in the same cycle a waiting result is transferred;
// bytes stall only while a result sits unread and rsp_tready is low. Lead bytes:
// 0xxxxxxx is a 7-bit value; 10/110/1110 prefixes carry 14/21/28 bits over 2..4 bytes;
// 111100xx and 111101xx are followed by a big-endian 32- or 64-bit value; 111110xx
// toggles a complement of the next integer; 111111xx is the value -1..-4.
`include "prefix_varint_decoder_defines.svh"

module prefix_varint_decoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [pvd_pkg::ByteW-1:0]  req_tdata,   // [7:0] stream_byte
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [pvd_pkg::RspW-1:0]   rsp_tdata    // [63:0] decoded_value,
                                                   // [67:64] encoded_length, rest zero
);

   // decode state
   logic [pvd_pkg::PendW-1:0]  pend_ff, pend_in;
   logic [pvd_pkg::ValueW-1:0] acc_ff, acc_in;
   logic                       neg_ff, neg_in;
   logic [pvd_pkg::LenW-1:0]   cnt_ff, cnt_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [pvd_pkg::ValueW-1:0] rsp_value_ff, rsp_value_in;
   logic [pvd_pkg::LenW-1:0]   rsp_len_ff, rsp_len_in;

   logic                       req_accept;
   logic                       emit;
   logic [pvd_pkg::ValueW-1:0] raw_value;
   logic [pvd_pkg::LenW-1:0]   cnt_inc;
   logic [pvd_pkg::PendW-1:0]  pend_dec;
   logic [pvd_pkg::ValueW-1:0] acc_shift;
   logic [pvd_pkg::ByteW-1:0]  b;

   // accept a byte whenever the result slot is free or drains this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign b          = req_tdata;

   assign cnt_inc   = (cnt_ff == pvd_pkg::LenMax) ? cnt_ff : cnt_ff + 1'b1;
   assign pend_dec  = pend_ff - 1'b1;
   assign acc_shift = {acc_ff[pvd_pkg::ValueW-pvd_pkg::ByteW-1:0], b};

   // byte decode: next state, and the raw value when an integer completes
   always_comb begin
      pend_in   = pend_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_inc;
      emit      = 1'b0;
      raw_value = acc_shift;

      if (pend_ff != '0) begin
         // follow-on byte: shift in, finish when the count runs out
         acc_in  = acc_shift;
         pend_in = pend_dec;
         if (pend_dec == '0) begin
            emit      = 1'b1;
            raw_value = acc_shift;
         end
      end else if ((b & pvd_pkg::MaskTop1) == pvd_pkg::PatOne) begin
         emit      = 1'b1;
         raw_value = pvd_pkg::widen(b & pvd_pkg::Mask7);
      end else if ((b & pvd_pkg::MaskTop2) == pvd_pkg::PatTwo) begin
         acc_in  = pvd_pkg::widen(b & pvd_pkg::Mask6);
         pend_in = pvd_pkg::PendTwo;
      end else if ((b & pvd_pkg::MaskTop4) == pvd_pkg::PatExt) begin
         case (b & pvd_pkg::MaskTop6)
            pvd_pkg::CodeWord32: begin
               acc_in  = '0;
               pend_in = pvd_pkg::PendW32;
            end
            pvd_pkg::CodeWord64: begin
               acc_in  = '0;
               pend_in = pvd_pkg::PendW64;
            end
            pvd_pkg::CodeNegate: begin
               neg_in = !neg_ff;
            end
            default: begin
               // short negative form
               emit      = 1'b1;
               raw_value = ~pvd_pkg::widen(b & pvd_pkg::Mask2);
            end
         endcase
      end else if ((b & pvd_pkg::MaskTop4) == pvd_pkg::PatFour) begin
         acc_in  = pvd_pkg::widen(b & pvd_pkg::Mask4);
         pend_in = pvd_pkg::PendFour;
      end else begin
         // remaining lead bytes are 110xxxxx
         acc_in  = pvd_pkg::widen(b & pvd_pkg::Mask5);
         pend_in = pvd_pkg::PendThree;
      end

      if (emit) begin
         // completion clears the decode state
         pend_in = '0;
         acc_in  = '0;
         neg_in  = 1'b0;
         cnt_in  = '0;
      end
   end

   // result slot: load on completion, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_len_in   = rsp_len_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = neg_ff ? ~raw_value : raw_value;
         rsp_len_in   = cnt_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            pend_ff <= pend_in;
            acc_ff  <= acc_in;
            neg_ff  <= neg_in;
            cnt_ff  <= cnt_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds without reset
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(pvd_pkg::RspW-pvd_pkg::ValueW-pvd_pkg::LenW){1'b0}},
                        rsp_len_ff, rsp_value_ff};

   // checks
   `PVD_ASSERT(a_pend_range, clock, reset, pend_ff <= pvd_pkg::PendW64,
      "pending count too large")
   `PVD_ASSERT(a_len_nonzero, clock, reset, !rsp_valid_ff || rsp_len_ff != '0,
      "zero length result")
   `PVD_ASSERT_NEXT(a_emit_clears, clock, reset, req_accept && emit,
      cnt_ff == '0 && !neg_ff && pend_ff == '0 && rsp_valid_ff,
      "completion did not clear state")
   `PVD_ASSERT_NEXT(a_idle_no_rsp, clock, reset, !req_accept && !rsp_valid_ff,
      !rsp_valid_ff, "result without a transfer")

endmodule

@@ dv/prefix_varint_decoder_checker.sv @@
// Scoreboard for the prefix varint decoder: tracks req_ and rsp_ transfers.
// Predicts each decoded integer and compares it with the rsp_ channel. Needs pvd_pkg.
`timescale 1ns / 1ps

module prefix_varint_decoder_checker
   import pvd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [ByteW-1:0]  req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RspW-1:0]   rsp_tdata,
   output int                fail_count,
   output int                checked_count,
   output int                outstanding
);

   typedef struct packed {
      logic [ValueW-1:0] value;
      logic [LenW-1:0]   length;
   } decoded_int_type;

   decoded_int_type   expected_ints[$];

   logic [PendW-1:0]  follow_left;
   logic [ValueW-1:0] gathered;
   logic              invert;
   logic [LenW-1:0]   tally;

   task automatic decode_byte(input logic [ByteW-1:0] b);
      logic [ValueW-1:0] word;
      logic              done;
      done = 1'b0;
      word = '0;
      if (tally != LenMax) tally++;
      if (follow_left != '0) begin
         gathered = {gathered[ValueW-ByteW-1:0], b};
         follow_left--;
         if (follow_left == '0) begin
            done = 1'b1;
            word = gathered;
         end
      end else if ((b & MaskTop1) == PatOne) begin
         done = 1'b1;
         word = ValueW'(b & Mask7);
      end else if ((b & MaskTop2) == PatTwo) begin
         gathered    = ValueW'(b & Mask6);
         follow_left = PendTwo;
      end else if ((b & MaskTop4) == PatExt) begin
         case (b & MaskTop6)
            CodeWord32: begin
               gathered    = '0;
               follow_left = PendW32;
            end
            CodeWord64: begin
               gathered    = '0;
               follow_left = PendW64;
            end
            CodeNegate: begin
               invert = ~invert;
            end
            default: begin
               done = 1'b1;
               word = ~ValueW'(b & Mask2);
            end
         endcase
      end else if ((b & MaskTop4) == PatFour) begin
         gathered    = ValueW'(b & Mask4);
         follow_left = PendFour;
      end else begin
         gathered    = ValueW'(b & Mask5);
         follow_left = PendThree;
      end
      if (done) begin
         if (invert) word = ~word;
         expected_ints.push_back('{value: word, length: tally});
         invert      = 1'b0;
         tally       = '0;
         gathered    = '0;
         follow_left = '0;
      end
   endtask

   initial begin
      fail_count    = 0;
      checked_count = 0;
      outstanding   = 0;
      follow_left   = '0;
      gathered      = '0;
      invert        = 1'b0;
      tally         = '0;
   end

   always @(posedge clock) begin
      decoded_int_type got;
      decoded_int_type want;
      logic [RspW-ValueW-LenW-1:0] pad;
      if (reset) begin
         follow_left = '0;
         gathered    = '0;
         invert      = 1'b0;
         tally       = '0;
         expected_ints.delete();
      end else begin
         // the result register makes any result seen now older than this edge's byte
         if (rsp_tvalid && rsp_tready) begin
            got.value  = rsp_tdata[ValueW-1:0];
            got.length = rsp_tdata[ValueW +: LenW];
            pad        = rsp_tdata[RspW-1:ValueW+LenW];
            if (expected_ints.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, got value %h length %0d",
                        $time, got.value, got.length);
            end else begin
               want = expected_ints.pop_front();
               checked_count++;
               if (got.value !== want.value || got.length !== want.length
                   || pad !== '0) begin
                  fail_count++;
                  $display("%0t: mismatch, expected value %h length %0d pad 0",
                           $time, want.value, want.length);
                  $display("%0t:           actual value %h length %0d pad %h",
                           $time, got.value, got.length, pad);
               end
            end
         end
         if (req_tvalid && req_tready) decode_byte(req_tdata);
      end
      outstanding = expected_ints.size();
   end

endmodule

@@ dv/prefix_varint_decoder_tb.sv @@
// Top of the prefix varint decoder testbench: clock, reset, byte stimulus and verdict.
// Needs pvd_pkg, the decoder RTL and prefix_varint_decoder_checker.
`timescale 1ns / 1ps

module prefix_varint_decoder_tb;
   import pvd_pkg::*;

   localparam int RandomItems = 600;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [ByteW-1:0]  req_tdata;    // [7:0] stream_byte
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RspW-1:0]   rsp_tdata;    // [63:0] decoded_value, [67:64] encoded_length

   int                fail_count;
   int                checked_count;
   int                outstanding;
   int                bytes_sent;
   logic              quiet;        // no idling on either side while set

   prefix_varint_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   prefix_varint_decoder_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .checked_count (checked_count),
      .outstanding   (outstanding)
   );

   // 4 ns period
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // mostly short idle stretches, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Present one byte at the falling edge and hold it until the decoder takes it.
   // Inputs only move at falling edges, so each edge sees one assignment per signal.
   task automatic send_byte(input logic [ByteW-1:0] b);
      int gap;
      gap = quiet ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      // alternate calm stretches with idling ones
      quiet = ((bytes_sent / 120) % 4) == 2;
   endtask

   // follow-on byte, biased toward all-zero and all-one patterns
   function automatic logic [ByteW-1:0] follow_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return ByteW'($urandom_range(0, 255));
   endfunction

   // Send one well-formed integer, optionally behind a chain of negation prefixes.
   task automatic send_random_integer();
      int               r;
      int               prefixes;
      int               follow;
      logic [ByteW-1:0] lead;
      r = $urandom_range(0, 99);
      if (r < 70)      prefixes = 0;
      else if (r < 85) prefixes = 1;
      else if (r < 95) prefixes = 2;
      else             prefixes = $urandom_range(13, 17);   // drives the count to or near saturation
      repeat (prefixes) send_byte(CodeNegate | ByteW'($urandom_range(0, 3)));
      case ($urandom_range(0, 6))
         0: begin
            lead   = ByteW'($urandom_range(0, 127));
            follow = 0;
         end
         1: begin
            lead   = PatTwo | (ByteW'($urandom_range(0, 255)) & Mask6);
            follow = 1;
         end
         2: begin
            lead   = PatThree | (ByteW'($urandom_range(0, 255)) & Mask5);
            follow = 2;
         end
         3: begin
            lead   = PatFour | (ByteW'($urandom_range(0, 255)) & Mask4);
            follow = 3;
         end
         4: begin
            lead   = CodeWord32 | (ByteW'($urandom_range(0, 255)) & Mask2);
            follow = 4;
         end
         5: begin
            lead   = CodeWord64 | (ByteW'($urandom_range(0, 255)) & Mask2);
            follow = 8;
         end
         default: begin
            lead   = CodeShortM | (ByteW'($urandom_range(0, 255)) & Mask2);
            follow = 0;
         end
      endcase
      send_byte(lead);
      repeat (follow) send_byte(follow_byte());
   endtask

   // Receiver: random stalls, or always ready during calm stretches.
   initial begin
      int stall;
      int burst;
      rsp_tready = 1'b0;
      forever begin
         if (quiet) begin
            @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            stall = pick_gap();
            burst = $urandom_range(1, 8);
            repeat (stall) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
            repeat (burst) begin
               @(negedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // Hard stop: far beyond the slowest legal run of about 650 bytes.
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      logic [ByteW-1:0] directed[$];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      bytes_sent = 0;
      quiet      = 1'b0;

      // hold reset, release at a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // one-byte zero and the short form -4
      directed = '{8'h00, 8'hFF};
      // two-, three- and four-byte forms
      directed = {directed, 8'hBF, 8'h01};
      directed = {directed, 8'hC5, 8'h12, 8'h34};
      directed = {directed, 8'hEF, 8'hFF, 8'hFF, 8'hFF};
      // 32-bit form with ignored low bits set, then the 64-bit form at its minimum
      directed = {directed, 8'hF3, 8'h80, 8'h00, 8'h00, 8'h01};
      directed = {directed, 8'hF4, 8'h80, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'h00, 8'h00};
      // two prefixes cancel, then a negated short form comes back positive
      directed = {directed, 8'hF9, 8'hFA, 8'hFC};
      directed = {directed, 8'hF8, 8'hFD};
      // fifteen prefixes push the length past its ceiling
      repeat (15) directed.push_back(CodeNegate);
      directed.push_back(8'h2A);
      foreach (directed[i]) send_byte(directed[i]);

      // random part: mostly whole integers, some raw noise bytes
      while (bytes_sent < RandomItems + directed.size()) begin
         if ($urandom_range(0, 99) < 15) send_byte(ByteW'($urandom_range(0, 255)));
         else send_random_integer();
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain the result register, then let the bench idle before the verdict
      wait (outstanding == 0);
      repeat (8) @(posedge clock);

      $display("Sent %0d stream bytes over every lead form, prefix chains and noise.",
               bytes_sent);
      $display("Compared %0d decoded integers against the prediction.", checked_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
